// ----- rtl/core/s3x_pkg.sv -----
// Shared types and constants of the Scale3x pixel-art magnifier.
// No dependencies; every other file of the core imports this package.
package s3x_pkg;

    // Default sizes of the core
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_PIXEL_BITS = 32;

    // Port field widths
    localparam int IN_PIX_BITS  = 32;
    localparam int OUT_PIX_BITS = 32;
    localparam int COORD_BITS   = 11;

    // Configuration port
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);
    localparam logic [CFG_BITS-1:0]     IMAGE_WIDTH_RST  = CFG_BITS'(320);
    localparam logic [CFG_BITS-1:0]     IMAGE_HEIGHT_RST = CFG_BITS'(240);

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Which blocks a source pixel completes, plus the edge facts that steer clamping
    typedef struct packed {
        logic up_prev;   // block (c-1, r-1)
        logic up_edge;   // block (c,   r-1), last column
        logic low_prev;  // block (c-1, r),   last row
        logic low_edge;  // block (c,   r),   last row and last column
        logic col_is0;
        logic col_is1;
        logic row_is0;
        logic row_is1;
    } t_job_flags;

    // Kind of block under construction in the back end
    typedef enum logic [1:0] {
        KIND_UP_PREV,
        KIND_UP_EDGE,
        KIND_LOW_PREV,
        KIND_LOW_EDGE
    } t_blk_kind;

endpackage

// ----- rtl/core/s3x_if.sv -----
// Valid/ready channel interfaces of the Scale3x core: source pixels in, 3x3 blocks out.
// Depends on s3x_pkg for the field widths.
interface s3x_pix_if import s3x_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IN_PIX_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface s3x_blk_if import s3x_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OUT_PIX_BITS-1:0] top_left;
    logic [OUT_PIX_BITS-1:0] top_mid;
    logic [OUT_PIX_BITS-1:0] top_right;
    logic [OUT_PIX_BITS-1:0] mid_left;
    logic [OUT_PIX_BITS-1:0] center_px;
    logic [OUT_PIX_BITS-1:0] mid_right;
    logic [OUT_PIX_BITS-1:0] bottom_left;
    logic [OUT_PIX_BITS-1:0] bottom_mid;
    logic [OUT_PIX_BITS-1:0] bottom_right;
    logic [COORD_BITS-1:0]   block_col;
    logic [COORD_BITS-1:0]   block_row;
    logic                    frame_last;

    modport source (output valid, output top_left, output top_mid, output top_right,
                    output mid_left, output center_px, output mid_right,
                    output bottom_left, output bottom_mid, output bottom_right,
                    output block_col, output block_row, output frame_last,
                    input ready);
    modport sink   (input valid, input top_left, input top_mid, input top_right,
                    input mid_left, input center_px, input mid_right,
                    input bottom_left, input bottom_mid, input bottom_right,
                    input block_col, input block_row, input frame_last,
                    output ready);
endinterface

// ----- rtl/core/s3x_front.sv -----
// Front end of the Scale3x core: size registers, raster counters, two line stores,
// the 3x3 window, and classification of each pixel into the blocks it completes.
// Depends on s3x_pkg and s3x_if.
module s3x_front import s3x_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    s3x_pix_if.sink                      i_pix,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output t_job_flags                   o_job_flags,
    output logic [CW-1:0]                o_job_col,
    output logic [RW-1:0]                o_job_row,
    output logic [2:0][2:0][PIXEL_BITS-1:0] o_job_win
);
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;

    logic [CFG_BITS-1:0]   r_image_width;
    logic [CFG_BITS-1:0]   r_image_height;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;

    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic                  last_col;
    logic                  last_row;
    logic                  accept;

    // Line stores
    logic [PIXEL_BITS-1:0] r_upper_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_middle_mem [MAX_WIDTH];

    // Second stage: the accepted pixel and the column read from the line stores
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_col;
    logic [RW-1:0]         r_s1_row;
    logic                  r_s1_last_col;
    logic                  r_s1_last_row;
    logic [PIXEL_BITS-1:0] r_rd_up;
    logic [PIXEL_BITS-1:0] r_rd_mid;
    logic                  s1_adv;
    t_job_flags            flags;

    // Two stored window columns: c-2 and c-1, rows r-2, r-1, r
    logic [2:0][PIXEL_BITS-1:0] r_win_col0;
    logic [2:0][PIXEL_BITS-1:0] r_win_col1;

    // Clamp the configured sizes to 1..MAX
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_image_height);
        end
    end

    assign last_col = ((WW'(r_col) + WW'(1)) == w_eff);
    assign last_row = ((HW'(r_row) + HW'(1)) == h_eff);

    always_comb begin
        flags.up_prev  = (r_s1_row != '0) && (r_s1_col != '0);
        flags.up_edge  = (r_s1_row != '0) && r_s1_last_col;
        flags.low_prev = r_s1_last_row && (r_s1_col != '0);
        flags.low_edge = r_s1_last_row && r_s1_last_col;
        flags.col_is0  = (r_s1_col == '0);
        flags.col_is1  = (r_s1_col == CW'(1));
        flags.row_is0  = (r_s1_row == '0);
        flags.row_is1  = (r_s1_row == RW'(1));
    end

    // A pixel that completes no block retires without a queue entry
    assign o_job_valid = r_s1_valid &&
                         (flags.up_prev || flags.up_edge || flags.low_prev || flags.low_edge);
    assign s1_adv      = r_s1_valid && (!o_job_valid || i_job_ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    assign o_job_flags  = flags;
    assign o_job_col    = r_s1_col;
    assign o_job_row    = r_s1_row;
    assign o_job_win[0] = r_win_col0;
    assign o_job_win[1] = r_win_col1;
    assign o_job_win[2] = {r_s1_px, r_rd_mid, r_rd_up};

    // Size registers and raster position; a size write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                    r_col         <= '0;
                    r_row         <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Line stores: shift the column down on retire, read the next column on accept.
    // Forward the column being written when both hit the same address (width of one).
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_upper_mem[r_s1_col]  <= r_rd_mid;
            r_middle_mem[r_s1_col] <= r_s1_px;
        end
        if (accept) begin
            if (s1_adv && (r_s1_col == r_col)) begin
                r_rd_up  <= r_rd_mid;
                r_rd_mid <= r_s1_px;
            end else begin
                r_rd_up  <= r_upper_mem[r_col];
                r_rd_mid <= r_middle_mem[r_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px       <= PIXEL_BITS'(i_pix.pixel);
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
        end
    end

    // Slide the window by one column on retire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_col0 <= '0;
            r_win_col1 <= '0;
        end else if (s1_adv) begin
            r_win_col0 <= r_win_col1;
            r_win_col1 <= {r_s1_px, r_rd_mid, r_rd_up};
        end
    end

endmodule

// ----- rtl/core/s3x_queue.sv -----
// Short job queue between the front and back ends of the Scale3x core.
// Depends on s3x_pkg for the default depth.
module s3x_queue import s3x_pkg::*; #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  logic [DATA_BITS-1:0] i_push_data,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output logic [DATA_BITS-1:0] o_pop_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]      r_wr_ptr;
    logic [PTRW-1:0]      r_rd_ptr;
    logic [CNTW-1:0]      r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != CNTW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/s3x_back.sv -----
// Back end of the Scale3x core: walks the blocks of one job, one block per cycle while o_blk
// is ready, applies the Scale3x rules and holds the result in the output register.
// Depends on s3x_pkg and s3x_if.
module s3x_back import s3x_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  t_job_flags                   i_job_flags,
    input  logic [CW-1:0]                i_job_col,
    input  logic [RW-1:0]                i_job_row,
    input  logic [2:0][2:0][PIXEL_BITS-1:0] i_job_win,
    s3x_blk_if.source                    o_blk
);
    logic [3:0]            r_done;
    logic [3:0]            pending;
    logic [3:0]            sel_oh;
    t_blk_kind             kind;
    logic                  lower;
    logic                  edge_blk;
    logic [1:0]            lsel;
    logic [1:0]            msel;
    logic [1:0]            usel;
    logic [1:0]            mdsel;
    logic [PIXEL_BITS-1:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
    logic [8:0][PIXEL_BITS-1:0] p;
    logic [CW-1:0]         bx;
    logic [RW-1:0]         by;
    logic                  emit;

    logic                         r_out_valid;
    logic [8:0][OUT_PIX_BITS-1:0] r_px;
    logic [COORD_BITS-1:0]        r_bcol;
    logic [COORD_BITS-1:0]        r_brow;
    logic                         r_last;

    assign pending = {i_job_flags.low_edge, i_job_flags.low_prev,
                      i_job_flags.up_edge, i_job_flags.up_prev} & ~r_done;

    // Blocks of the row above first, each row left to right
    always_comb begin
        if (pending[0]) begin
            kind   = KIND_UP_PREV;
            sel_oh = 4'b0001;
        end else if (pending[1]) begin
            kind   = KIND_UP_EDGE;
            sel_oh = 4'b0010;
        end else if (pending[2]) begin
            kind   = KIND_LOW_PREV;
            sel_oh = 4'b0100;
        end else begin
            kind   = KIND_LOW_EDGE;
            sel_oh = 4'b1000;
        end
    end

    // Clamp-to-edge neighbour selection
    always_comb begin
        lower    = (kind == KIND_LOW_PREV) || (kind == KIND_LOW_EDGE);
        edge_blk = (kind == KIND_UP_EDGE)  || (kind == KIND_LOW_EDGE);
        if (edge_blk) begin
            lsel = i_job_flags.col_is0 ? 2'd2 : 2'd1;
            msel = 2'd2;
        end else begin
            lsel = i_job_flags.col_is1 ? 2'd1 : 2'd0;
            msel = 2'd1;
        end
        if (lower) begin
            usel  = i_job_flags.row_is0 ? 2'd2 : 2'd1;
            mdsel = 2'd2;
        end else begin
            usel  = i_job_flags.row_is1 ? 2'd1 : 2'd0;
            mdsel = 2'd1;
        end
        bx = edge_blk ? i_job_col : i_job_col - CW'(1);
        by = lower    ? i_job_row : i_job_row - RW'(1);
    end

    assign pa = i_job_win[lsel][usel];
    assign pb = i_job_win[msel][usel];
    assign pc = i_job_win[2][usel];
    assign pd = i_job_win[lsel][mdsel];
    assign pe = i_job_win[msel][mdsel];
    assign pf = i_job_win[2][mdsel];
    assign pg = i_job_win[lsel][2];
    assign ph = i_job_win[msel][2];
    assign pi = i_job_win[2][2];

    // Scale3x rules
    always_comb begin
        p = {9{pe}};
        if ((pb != ph) && (pd != pf)) begin
            if (pd == pb) p[0] = pd;
            if (((pd == pb) && (pe != pc)) || ((pb == pf) && (pe != pa))) p[1] = pb;
            if (pb == pf) p[2] = pf;
            if (((pd == pb) && (pe != pg)) || ((pd == ph) && (pe != pa))) p[3] = pd;
            if (((pb == pf) && (pe != pi)) || ((ph == pf) && (pe != pc))) p[5] = pf;
            if (pd == ph) p[6] = pd;
            if (((pd == ph) && (pe != pi)) || ((ph == pf) && (pe != pg))) p[7] = ph;
            if (ph == pf) p[8] = pf;
        end
    end

    assign emit        = i_job_valid && (!r_out_valid || o_blk.ready);
    assign o_job_ready = emit && ((pending & ~sel_oh) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_done <= o_job_ready ? '0 : (r_done | sel_oh);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_blk.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int k = 0; k < 9; k++) begin
                r_px[k] <= OUT_PIX_BITS'(p[k]);
            end
            r_bcol <= COORD_BITS'(bx);
            r_brow <= COORD_BITS'(by);
            r_last <= (kind == KIND_LOW_EDGE);
        end
    end

    assign o_blk.valid        = r_out_valid;
    assign o_blk.top_left     = r_px[0];
    assign o_blk.top_mid      = r_px[1];
    assign o_blk.top_right    = r_px[2];
    assign o_blk.mid_left     = r_px[3];
    assign o_blk.center_px    = r_px[4];
    assign o_blk.mid_right    = r_px[5];
    assign o_blk.bottom_left  = r_px[6];
    assign o_blk.bottom_mid   = r_px[7];
    assign o_blk.bottom_right = r_px[8];
    assign o_blk.block_col    = r_bcol;
    assign o_blk.block_row    = r_brow;
    assign o_blk.frame_last   = r_last;

endmodule

// ----- rtl/core/pixel_art_scale3x_core.sv -----
// Scale3x pixel-art magnifier core. A block passes the front's pixel register, the job queue
// and the back end's output register. Throughput: one pixel per cycle while the queue has
// room; a pixel that completes several blocks (up to four at row ends and on the last row)
// holds the back end until each is emitted, one block per cycle while o_blk is ready.
// Reset (synchronous, active low): size registers go to 320 x 240, the raster position to
// zero, queue and output empty; the line stores are not cleared and take no clearing pass.
module pixel_art_scale3x_core import s3x_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    s3x_pix_if.sink                 i_pix,
    s3x_blk_if.source               o_blk
);
    // Coordinate widths follow the largest frame
    localparam int CW       = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WIN_BITS = 9 * PIXEL_BITS;
    localparam int JOB_BITS = $bits(t_job_flags) + CW + RW + WIN_BITS;

    // Front to queue
    logic                            job_valid;
    logic                            job_ready;
    t_job_flags                      job_flags;
    logic [CW-1:0]                   job_col;
    logic [RW-1:0]                   job_row;
    logic [2:0][2:0][PIXEL_BITS-1:0] job_win;

    // Queue to back
    logic                            q_valid;
    logic                            q_ready;
    logic [JOB_BITS-1:0]             q_data;
    t_job_flags                      q_flags;
    logic [CW-1:0]                   q_col;
    logic [RW-1:0]                   q_row;
    logic [2:0][2:0][PIXEL_BITS-1:0] q_win;

    // Front: count the raster, read the line stores, keep the window,
    // and tag each pixel with the blocks it completes.
    s3x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_flags (job_flags),
        .o_job_col   (job_col),
        .o_job_row   (job_row),
        .o_job_win   (job_win)
    );

    // Queue: absorb bursts of multi-block pixels so the front keeps taking items
    s3x_queue #(
        .DATA_BITS (JOB_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid),
        .o_push_ready (job_ready),
        .i_push_data  ({job_flags, job_col, job_row, job_win}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign {q_flags, q_col, q_row, q_win} = q_data;

    // Back: emit the blocks of the head job in order, one per cycle while o_blk is ready
    s3x_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job_flags (q_flags),
        .i_job_col   (q_col),
        .i_job_row   (q_row),
        .i_job_win   (q_win),
        .o_blk       (o_blk)
    );

    // Only pixels that complete a block enter the queue
    a_job_has_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> (job_flags.up_prev || job_flags.up_edge ||
                       job_flags.low_prev || job_flags.low_edge))
        else $error("job pushed without any block");

    // The back end retires only a job that is present
    a_pop_when_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ready |-> q_valid)
        else $error("job retired from an empty queue");

    // A job the queue refused stays with the front, its flags and column unchanged
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && !job_ready) |=> (job_valid && $stable(job_flags) && $stable(job_col)))
        else $error("refused job dropped or changed");

    // The frame's final block is always a last-row, last-column block
    a_last_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && !q_flags.low_edge) |=> !(o_blk.valid && o_blk.frame_last
                                                       && $past(!o_blk.valid || o_blk.ready)))
        else $error("frame end flagged on a job without the final block");

endmodule
